FILE: design/rpsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpsp_pkg;

   localparam int READY_DEPTH = 64;
   localparam int SWAP_DEPTH  = 64;

   localparam int RAW   = $clog2(READY_DEPTH);
   localparam int SAW   = $clog2(SWAP_DEPTH);
   localparam int RCW   = $clog2(READY_DEPTH + 1);
   localparam int SCW   = $clog2(SWAP_DEPTH + 1);
   localparam int PTR_W = (RCW > SCW) ? RCW : SCW;

   localparam logic [1:0] OP_ADD_READY = 2'd0;
   localparam logic [1:0] OP_ADD_SWAP  = 2'd1;
   localparam logic [1:0] OP_POP       = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   localparam logic [2:0] ST_POP_READY = 3'd0;
   localparam logic [2:0] ST_POP_SWAP  = 3'd1;
   localparam logic [2:0] ST_NONE      = 3'd2;
   localparam logic [2:0] ST_INSERTED  = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] current_time;
      logic [15:0] process_id;
      logic [31:0] arrival_time;
      logic [15:0] mem_amount;
      logic [15:0] run_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] chosen_id;
      logic [31:0] chosen_arrival;
      logic [15:0] chosen_mem_amount;
      logic [15:0] chosen_run_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0] arrival;
      logic [15:0] id;
      logic [15:0] mem_amount;
      logic [15:0] run_length;
   } ready_ent_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic [15:0] id;
      logic [31:0] arrival;
      logic [15:0] mem_amount;
      logic [15:0] run_length;
   } swap_ent_type;

endpackage
`default_nettype wire

FILE: design/rpsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rpsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/ready_swap_process_picker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Ready/swap process picker.
// Requests enter on req_ (valid/stall, payload req_data); each gives exactly one
// result on rsp_ (valid/stall, payload rsp_data). Operations: add to the ready
// table, add to the swap table (stamped with current_time), pop the next process.
// Both tables live in single-port-read synchronous RAMs with a registered read.
// An insert (or a refused insert) is answered in the cycle after it is accepted.
// A pop reads the two heads, scans the swap table and/or the ready head's
// arrival group, then compacts the chosen table by reading entry i+1 and
// writing it to i, one entry per cycle.
// One request is in flight at a time; req_stall is high while a pop works or
// while an earlier result still sits unaccepted in the output register.
// When the receiver stalls, the result is held in rsp_data until taken.
// Reset (synchronous, active high) empties both tables by clearing their counts;
// no clearing pass is needed since only entries below the counts are read.
module ready_swap_process_picker_core
   import rpsp_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_data
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HEAD  = 3'd1;
   localparam logic [2:0] S_SSCAN = 3'd2;
   localparam logic [2:0] S_RSCAN = 3'd3;
   localparam logic [2:0] S_COMP  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [RCW-1:0]   rcnt_ff, rcnt_in;
   logic [SCW-1:0]   scnt_ff, scnt_in;
   logic [31:0]      now_ff, now_in;
   ready_ent_type    rbest_ff, rbest_in;
   swap_ent_type     sbest_ff, sbest_in;
   logic [PTR_W-1:0] rbidx_ff, rbidx_in;
   logic [PTR_W-1:0] sbidx_ff, sbidx_in;
   logic [15:0]      low_ff, low_in;
   logic             eq_ff, eq_in;
   logic             side_ff, side_in;   // 1: swap table
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] pidx_ff, pidx_in;
   logic             pend_ff, pend_in;
   logic             stop_ff, stop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   ready_ent_type    r_rdata, r_wdata;
   swap_ent_type     s_rdata, s_wdata;
   logic             r_we, s_we;
   logic [RAW-1:0]   r_waddr, r_raddr;
   logic [SAW-1:0]   s_waddr, s_raddr;

   logic             accept, slot_free, issue, arrived;
   logic [PTR_W-1:0] rcnt_x, scnt_x, wr_idx;
   ready_ent_type    req_rent;
   swap_ent_type     req_sent;

   rpsp_ram #(.WIDTH($bits(ready_ent_type)), .DEPTH(READY_DEPTH)) u_ready_ram (
      .clock  (clock),
      .wr_en  (r_we),
      .wr_addr(r_waddr),
      .wr_data(r_wdata),
      .rd_addr(r_raddr),
      .rd_data(r_rdata)
   );

   rpsp_ram #(.WIDTH($bits(swap_ent_type)), .DEPTH(SWAP_DEPTH)) u_swap_ram (
      .clock  (clock),
      .wr_en  (s_we),
      .wr_addr(s_waddr),
      .wr_data(s_wdata),
      .rd_addr(s_raddr),
      .rd_data(s_rdata)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rcnt_x = PTR_W'(rcnt_ff);
   assign scnt_x = PTR_W'(scnt_ff);
   assign wr_idx = pidx_ff - PTR_W'(1);

   // RAM addressing: heads are read as the pop is accepted, then the pointer leads
   assign r_raddr = (state_ff == S_IDLE) ? RAW'(0) : ptr_ff[RAW-1:0];
   assign s_raddr = (state_ff == S_IDLE) ? SAW'(0) : ptr_ff[SAW-1:0];

   assign req_rent = '{arrival: req_data.arrival_time, id: req_data.process_id,
                       mem_amount: req_data.mem_amount, run_length: req_data.run_length};
   assign req_sent = '{stamp: req_data.current_time, id: req_data.process_id,
                       arrival: req_data.arrival_time, mem_amount: req_data.mem_amount,
                       run_length: req_data.run_length};

   assign arrived = (rcnt_ff != '0) && (r_rdata.arrival <= now_ff);

   always_comb begin
      state_in     = state_ff;
      rcnt_in      = rcnt_ff;
      scnt_in      = scnt_ff;
      now_in       = now_ff;
      rbest_in     = rbest_ff;
      sbest_in     = sbest_ff;
      rbidx_in     = rbidx_ff;
      sbidx_in     = sbidx_ff;
      low_in       = low_ff;
      eq_in        = eq_ff;
      side_in      = side_ff;
      ptr_in       = ptr_ff;
      pidx_in      = pidx_ff;
      pend_in      = pend_ff;
      stop_in      = stop_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      issue        = 1'b0;
      r_we         = 1'b0;
      s_we         = 1'b0;
      r_waddr      = rcnt_ff[RAW-1:0];
      s_waddr      = scnt_ff[SAW-1:0];
      r_wdata      = req_rent;
      s_wdata      = req_sent;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               now_in       = req_data.current_time;
               case (req_data.operation)
                  OP_ADD_READY: begin
                     if (rcnt_x == PTR_W'(READY_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        r_we          = 1'b1;
                        rcnt_in       = rcnt_ff + RCW'(1);
                        rsp_in.status = ST_INSERTED;
                     end
                  end
                  OP_ADD_SWAP: begin
                     if (scnt_x == PTR_W'(SWAP_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        s_we          = 1'b1;
                        scnt_in       = scnt_ff + SCW'(1);
                        rsp_in.status = ST_INSERTED;
                     end
                  end
                  OP_POP: begin
                     rsp_valid_in = 1'b0;
                     state_in     = S_HEAD;
                  end
                  default: begin
                     rsp_in.status = ST_NONE;
                  end
               endcase
            end
         end
         S_HEAD: begin
            rbest_in = r_rdata;
            sbest_in = s_rdata;
            rbidx_in = '0;
            sbidx_in = '0;
            low_in   = s_rdata.id;
            eq_in    = arrived && (r_rdata.arrival == s_rdata.stamp);
            ptr_in   = PTR_W'(1);
            pend_in  = 1'b0;
            stop_in  = 1'b0;
            if (scnt_ff != '0) begin
               if (arrived && (r_rdata.arrival < s_rdata.stamp)) begin
                  state_in = S_RSCAN;
               end else begin
                  state_in = S_SSCAN;
               end
            end else if (arrived) begin
               state_in = S_RSCAN;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.status = ST_NONE;
               state_in      = S_IDLE;
            end
         end
         S_SSCAN: begin
            issue   = ptr_ff < scnt_x;
            pend_in = issue;
            if (issue) begin
               ptr_in  = ptr_ff + PTR_W'(1);
               pidx_in = ptr_ff;
            end
            if (pend_ff) begin
               if ((s_rdata.stamp < sbest_ff.stamp) ||
                   ((s_rdata.stamp == sbest_ff.stamp) && (s_rdata.id < sbest_ff.id))) begin
                  sbest_in = s_rdata;
                  sbidx_in = pidx_ff;
               end
               if ((s_rdata.stamp == rbest_ff.arrival) && (s_rdata.id < low_ff)) begin
                  low_in = s_rdata.id;
               end
            end else if (!issue) begin
               pend_in = 1'b0;
               stop_in = 1'b0;
               if (eq_ff && (rbest_ff.id < low_ff)) begin
                  ptr_in   = PTR_W'(1);
                  state_in = S_RSCAN;
               end else begin
                  side_in  = 1'b1;
                  ptr_in   = sbidx_ff + PTR_W'(1);
                  state_in = S_COMP;
               end
            end
         end
         S_RSCAN: begin
            // leading run of equal arrival times only
            issue   = (ptr_ff < rcnt_x) && !stop_ff;
            pend_in = issue;
            if (issue) begin
               ptr_in  = ptr_ff + PTR_W'(1);
               pidx_in = ptr_ff;
            end
            if (pend_ff) begin
               if (!stop_ff) begin
                  if (r_rdata.arrival == rbest_ff.arrival) begin
                     if (r_rdata.id < rbest_ff.id) begin
                        rbest_in = r_rdata;
                        rbidx_in = pidx_ff;
                     end
                  end else begin
                     stop_in = 1'b1;
                  end
               end
            end else if (!issue) begin
               side_in  = 1'b0;
               ptr_in   = rbidx_ff + PTR_W'(1);
               state_in = S_COMP;
            end
         end
         S_COMP: begin
            // entry i+1 read this cycle is written to entry i the next
            issue   = ptr_ff < (side_ff ? scnt_x : rcnt_x);
            pend_in = issue;
            if (issue) begin
               ptr_in  = ptr_ff + PTR_W'(1);
               pidx_in = ptr_ff;
            end
            r_waddr = wr_idx[RAW-1:0];
            s_waddr = wr_idx[SAW-1:0];
            r_wdata = r_rdata;
            s_wdata = s_rdata;
            if (pend_ff) begin
               r_we = !side_ff;
               s_we = side_ff;
            end else if (!issue) begin
               rsp_valid_in = 1'b1;
               if (side_ff) begin
                  scnt_in = scnt_ff - SCW'(1);
                  rsp_in  = '{status: ST_POP_SWAP, chosen_id: sbest_ff.id,
                              chosen_arrival: sbest_ff.arrival,
                              chosen_mem_amount: sbest_ff.mem_amount,
                              chosen_run_length: sbest_ff.run_length};
               end else begin
                  rcnt_in = rcnt_ff - RCW'(1);
                  rsp_in  = '{status: ST_POP_READY, chosen_id: rbest_ff.id,
                              chosen_arrival: rbest_ff.arrival,
                              chosen_mem_amount: rbest_ff.mem_amount,
                              chosen_run_length: rbest_ff.run_length};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rcnt_ff      <= '0;
         scnt_ff      <= '0;
         pend_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rcnt_ff      <= rcnt_in;
         scnt_ff      <= scnt_in;
         pend_ff      <= pend_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff   <= now_in;
      rbest_ff <= rbest_in;
      sbest_ff <= sbest_in;
      rbidx_ff <= rbidx_in;
      sbidx_ff <= sbidx_in;
      low_ff   <= low_in;
      eq_ff    <= eq_in;
      side_ff  <= side_in;
      ptr_ff   <= ptr_in;
      pidx_ff  <= pidx_in;
      rsp_ff   <= rsp_in;
   end

`ifndef SYNTHESIS
   a_rcnt_range: assert property (@(posedge clock) disable iff (reset)
      rcnt_x <= PTR_W'(READY_DEPTH)) else $error("ready count overflow");
   a_scnt_range: assert property (@(posedge clock) disable iff (reset)
      scnt_x <= PTR_W'(SWAP_DEPTH)) else $error("swap count overflow");
   a_comp_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMP) && pend_ff |-> pidx_ff != '0)
      else $error("compaction write below entry zero");
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while a pop is in progress");
`endif
endmodule
`default_nettype wire

FILE: verif/process_picker_checker.sv
`timescale 1ns / 1ps
module process_picker_checker
   import rpsp_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      req_valid,
   input  wire      req_stall,
   input  req_type  req_data,
   input  wire      rsp_valid,
   input  wire      rsp_stall,
   input  rsp_type  rsp_data,
   output int       fail_count,
   output int       pending,
   output int       rsp_seen,
   output int       pops_ready,
   output int       pops_swap,
   output int       full_seen
);

   ready_ent_type ready_tab[$];
   swap_ent_type  swap_tab[$];
   rsp_type       expected_rsp[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic rsp_type take_ready_entry();
      rsp_type r;
      int best;
      best = 0;
      for (int i = 1; i < ready_tab.size() && ready_tab[i].arrival == ready_tab[0].arrival;
           i++)
         if (ready_tab[i].id < ready_tab[best].id) best = i;
      r = '0;
      r.status = ST_POP_READY;
      r.chosen_id = ready_tab[best].id;
      r.chosen_arrival = ready_tab[best].arrival;
      r.chosen_mem_amount = ready_tab[best].mem_amount;
      r.chosen_run_length = ready_tab[best].run_length;
      ready_tab.delete(best);
      return r;
   endfunction

   function automatic rsp_type take_swap_entry();
      rsp_type r;
      int best;
      best = 0;
      for (int i = 1; i < swap_tab.size(); i++)
         if (swap_tab[i].stamp < swap_tab[best].stamp ||
             (swap_tab[i].stamp == swap_tab[best].stamp && swap_tab[i].id < swap_tab[best].id))
            best = i;
      r = '0;
      r.status = ST_POP_SWAP;
      r.chosen_id = swap_tab[best].id;
      r.chosen_arrival = swap_tab[best].arrival;
      r.chosen_mem_amount = swap_tab[best].mem_amount;
      r.chosen_run_length = swap_tab[best].run_length;
      swap_tab.delete(best);
      return r;
   endfunction

   function automatic rsp_type pick_next(input req_type q);
      rsp_type r;
      ready_ent_type re;
      swap_ent_type se;
      logic arrived;
      logic [15:0] low;
      r = '0;
      r.status = ST_NONE;
      case (q.operation)
         OP_ADD_READY: begin
            if (ready_tab.size() >= READY_DEPTH) r.status = ST_FULL;
            else begin
               re = '{q.arrival_time, q.process_id, q.mem_amount, q.run_length};
               ready_tab.push_back(re);
               r.status = ST_INSERTED;
            end
         end
         OP_ADD_SWAP: begin
            if (swap_tab.size() >= SWAP_DEPTH) r.status = ST_FULL;
            else begin
               se = '{q.current_time, q.process_id, q.arrival_time, q.mem_amount,
                      q.run_length};
               swap_tab.push_back(se);
               r.status = ST_INSERTED;
            end
         end
         OP_POP: begin
            arrived = ready_tab.size() > 0 && ready_tab[0].arrival <= q.current_time;
            if (swap_tab.size() > 0) begin
               if (!arrived || ready_tab[0].arrival > swap_tab[0].stamp)
                  r = take_swap_entry();
               else if (ready_tab[0].arrival < swap_tab[0].stamp)
                  r = take_ready_entry();
               else begin
                  low = swap_tab[0].id;
                  foreach (swap_tab[i])
                     if (swap_tab[i].stamp == ready_tab[0].arrival && swap_tab[i].id < low)
                        low = swap_tab[i].id;
                  if (ready_tab[0].id < low) r = take_ready_entry();
                  else r = take_swap_entry();
               end
            end else if (arrived) r = take_ready_entry();
         end
         default: ;
      endcase
      return r;
   endfunction

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ready_tab.delete();
         swap_tab.delete();
         expected_rsp.delete();
         fail_count = 0;
         rsp_seen <= 0;
         pops_ready <= 0;
         pops_swap <= 0;
         full_seen <= 0;
      end else begin
         if (req_valid && !req_stall) expected_rsp.push_back(pick_next(req_data));
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (rsp_data.status == ST_POP_READY) pops_ready <= pops_ready + 1;
            if (rsp_data.status == ST_POP_SWAP) pops_swap <= pops_swap + 1;
            if (rsp_data.status == ST_FULL) full_seen <= full_seen + 1;
            if (expected_rsp.size() == 0) report_mismatch("unexpected result", 0, 0);
            else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.chosen_id !== want.chosen_id)
                  report_mismatch("chosen_id", rsp_data.chosen_id, want.chosen_id);
               if (rsp_data.chosen_arrival !== want.chosen_arrival)
                  report_mismatch("chosen_arrival", rsp_data.chosen_arrival,
                                  want.chosen_arrival);
               if (rsp_data.chosen_mem_amount !== want.chosen_mem_amount)
                  report_mismatch("chosen_mem_amount", rsp_data.chosen_mem_amount,
                                  want.chosen_mem_amount);
               if (rsp_data.chosen_run_length !== want.chosen_run_length)
                  report_mismatch("chosen_run_length", rsp_data.chosen_run_length,
                                  want.chosen_run_length);
            end
         end
      end
   end

endmodule

FILE: verif/ready_swap_process_picker_core_tb.sv
`timescale 1ns / 1ps
module ready_swap_process_picker_core_tb;
   import rpsp_pkg::*;

   localparam int IDLE_LIMIT = 20000;   // well above a worst-case pop plus a long stall

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int fail_count, pending, rsp_seen, pops_ready, pops_swap, full_seen;
   int idle_cycles;
   bit hold_off;        // long receiver hold-off requested by the sender side
   int sent;

   ready_swap_process_picker_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   process_picker_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen),
      .pops_ready(pops_ready), .pops_swap(pops_swap), .full_seen(full_seen)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Receiver: stalls on its own pattern - quiet stretches, random stalls,
   // and on request one long hold-off counted here.
   initial begin
      int mode_len, hold;
      bit held;
      rsp_stall = 0;
      held = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off && !held) begin
            rsp_stall <= 1;
            for (hold = 0; hold < 600; hold++) @(posedge clock);
            held = 1;
         end
         mode_len = $urandom_range(10, 200);
         case ($urandom_range(0, 2))
            0: for (int i = 0; i < mode_len; i++) begin
                  rsp_stall <= 0;
                  @(posedge clock);
               end
            1: for (int i = 0; i < mode_len; i++) begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
                  @(posedge clock);
               end
            default: for (int i = 0; i < mode_len; i++) begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
                  @(posedge clock);
               end
         endcase
      end
   end

   // Watchdog: cycles with no request or result accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   logic [31:0] sim_now;   // scheduler clock, mostly rising

   // Offer one request and hold it until accepted.
   task automatic send_request(input logic [1:0] op, input logic [31:0] now_t,
                               input logic [15:0] pid, input logic [31:0] arr,
                               input logic [15:0] mem, input logic [15:0] job);
      req_valid <= 1;
      req_data  <= '{op, now_t, pid, arr, mem, job};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic idle_request_side(input int n);
      req_valid <= 0;
      for (int i = 0; i < n; i++) @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Random request shaped like a scheduler trace: times creep forward,
   // ids drawn from a narrow range so equal-age ties are common.
   task automatic random_request();
      logic [1:0]  op;
      logic [31:0] arr;
      int r;
      r = $urandom_range(0, 99);
      op = (r < 35) ? OP_ADD_READY : (r < 60) ? OP_ADD_SWAP : (r < 98) ? OP_POP : OP_UNUSED;
      sim_now = sim_now + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) sim_now = $urandom;
      arr = ($urandom_range(0, 9) == 0) ? $urandom : sim_now + $urandom_range(0, 4) - 2;
      send_request(op, sim_now, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                   16'($urandom_range(0, 15)), arr, 16'($urandom), 16'($urandom));
   endtask

   initial begin
      int burst;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      sent = 0;
      sim_now = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty pop, unused code, equal-age ties, extremes
      send_request(OP_POP, 0, 0, 0, 0, 0);
      send_request(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_ADD_READY, 0, 16'd7, 32'd10, 16'hFFFF, 16'h0000);
      send_request(OP_ADD_READY, 0, 16'd3, 32'd10, 16'h0000, 16'hFFFF);
      send_request(OP_ADD_READY, 0, 16'd1, 32'd12, 16'h1234, 16'h5678);
      send_request(OP_POP, 32'd9, 0, 0, 0, 0);                  // head not arrived
      send_request(OP_ADD_SWAP, 32'd10, 16'd5, 32'hFFFF_FFFF, 16'hAAAA, 16'h5555);
      send_request(OP_ADD_SWAP, 32'd10, 16'd2, 32'd0, 16'h5555, 16'hAAAA);
      send_request(OP_POP, 32'd10, 0, 0, 0, 0);   // equal age: head id 7 vs swap low 2
      send_request(OP_POP, 32'd10, 0, 0, 0, 0);
      send_request(OP_POP, 32'd11, 0, 0, 0, 0);
      send_request(OP_POP, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_request(OP_POP, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_request(OP_POP, 32'hFFFF_FFFF, 0, 0, 0, 0);
      drain_all();

      // fill both tables past full, receiver held off meanwhile
      hold_off = 1;
      for (int i = 0; i < READY_DEPTH + 2; i++)
         send_request(OP_ADD_READY, 0, 16'(i), 32'(i / 4), 16'(i), 16'(~i));
      for (int i = 0; i < SWAP_DEPTH + 2; i++)
         send_request(OP_ADD_SWAP, 32'(i / 3), 16'(63 - i), 32'(i), 16'(~i), 16'(i));
      for (int i = 0; i < 10; i++) send_request(OP_POP, 32'hFFFF_FFFF, 0, 0, 0, 0);
      drain_all();
      // empty the tables so random traffic starts small
      for (int i = 0; i < READY_DEPTH + SWAP_DEPTH; i++)
         send_request(OP_POP, 32'hFFFF_FFFF, 0, 0, 0, 0);
      drain_all();

      // random bursts with gaps
      for (int n = 0; n < 1000; ) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst; i++) random_request();
         n += burst;
         if ($urandom_range(0, 1)) idle_request_side($urandom_range(1, 40));
         if ($urandom_range(0, 15) == 0) drain_all();
      end
      drain_all();
      repeat (200) @(posedge clock);

      $display("sent %0d requests, %0d results: %0d ready pops, %0d swap pops, %0d refused",
               sent, rsp_seen, pops_ready, pops_swap, full_seen);
      $display("covered empty and full tables, equal-age ties and long output stalls");
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
